// File: rtl/periodic_timer_table_core_defines.svh
// Assertion macros used by the timer table top level.
// Depends on nothing; the including module must have clk_i and rst_ni.
`ifndef PERIODIC_TIMER_TABLE_CORE_DEFINES_SVH
`define PERIODIC_TIMER_TABLE_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define PTT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define PTT_ASSERT_NEVER(label, cond, msg) \
  `PTT_ASSERT(label, !(cond), msg)
`else
`define PTT_ASSERT(label, prop, msg)
`define PTT_ASSERT_NEVER(label, cond, msg)
`endif

`endif

// File: rtl/ptt_pkg.sv
// Types and codes shared by the timer table cells and the top level.
// Depends on nothing.
package ptt_pkg;

  localparam int unsigned TimeW = 32;
  localparam int unsigned IdW   = 8;

  // Input operation codes.
  localparam logic [1:0] OP_SET    = 2'd0;
  localparam logic [1:0] OP_CANCEL = 2'd1;
  localparam logic [1:0] OP_TICK   = 2'd2;

  // Result kinds.
  localparam logic [1:0] KIND_SET_REPLY  = 2'd0;
  localparam logic [1:0] KIND_CANCEL_ACK = 2'd1;
  localparam logic [1:0] KIND_FIRED      = 2'd2;
  localparam logic [1:0] KIND_TICK_DONE  = 2'd3;

  localparam logic [TimeW-1:0] NO_DEADLINE = '1;

  // Scan token that walks the row of cells during a tick.
  typedef struct packed {
    logic             valid;
    logic [TimeW-1:0] now;
    logic [TimeW-1:0] min;
  } tok_t;

  // Slot write request broadcast to the cells; each cell has its own select.
  typedef struct packed {
    logic             set_en;
    logic             clr_en;
    logic [TimeW-1:0] deadline;
    logic [TimeW-1:0] interval;
  } wr_t;

endpackage

// File: rtl/periodic_timer_table_core.sv
// Timer table top level: request decode, output register and the row of slot cells.
// Depends on ptt_pkg, ptt_cell and periodic_timer_table_core_defines.svh.
//
// A table of SLOTS one-shot or periodic timers held in a row of identical cells, one
// slot per cell. The block takes one request at a time. A set request claims the
// lowest free slot and answers with its one-based id (0 when full); a cancel request
// frees a slot by id and flags an id of 0 or above SLOTS. Both are first held in the
// request registers, then commit the slot write and load the reply once the output
// is free. A tick request launches a scan token that moves one cell per cycle; each
// cell whose deadline has come emits a fired result as the token passes and then
// reloads (periodic) or frees itself (one-shot), and the token collects the earliest
// remaining deadline for the closing tick-done result. Any cycle in which the output
// register holds an untaken result stalls the scan. A request is accepted again once
// its final result has been loaded into the output register.
`include "periodic_timer_table_core_defines.svh"

module periodic_timer_table_core #(
  parameter int unsigned SLOTS = 4
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // Request stream.
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [103:0] s_axis_tdata,  // now[31:0], delay[63:32], period[95:64],
                                      // slot_id[103:96]
  input  logic [1:0]   s_axis_tuser,  // op[1:0]
  // Result stream.
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [47:0]  m_axis_tdata,  // slot[7:0], next_deadline[39:8], error[40],
                                      // zero[47:41]
  output logic [1:0]   m_axis_tuser,  // kind[1:0]
  output logic         m_axis_tlast
);
  import ptt_pkg::*;

  // Request holding registers.
  logic             busy_q;
  logic             pend_q;   // set or cancel waiting to commit
  logic [1:0]       op_q;
  logic [TimeW-1:0] now_q;
  logic [TimeW-1:0] rel_q;
  logic [TimeW-1:0] per_q;
  logic [IdW-1:0]   id_q;
  tok_t             tok0_q;

  // Output register.
  logic             out_valid_q;
  logic [1:0]       out_kind_q,  out_kind_d;
  logic [IdW-1:0]   out_slot_q,  out_slot_d;
  logic [TimeW-1:0] out_next_q,  out_next_d;
  logic             out_err_q,   out_err_d;
  logic             out_last_q,  out_last_d;

  // Cell row.
  tok_t             tok [SLOTS+1];
  logic [SLOTS-1:0] fire_vec;
  logic [IdW-1:0]   fire_id [SLOTS];
  logic [SLOTS-1:0] active_vec;
  logic [SLOTS-1:0] sel_vec;
  logic [SLOTS-1:0] free_onehot;
  logic [IdW-1:0]   free_id;
  logic             any_free;
  logic             cancel_ok;
  wr_t              wr;

  logic             step;
  logic             accept;
  logic             load;
  logic             fire_any;
  logic [IdW-1:0]   fire_slot;
  logic             commit;

  // The scan and the commit only advance when the output register can take a result.
  assign step   = !out_valid_q || m_axis_tready;
  assign accept = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = !busy_q;
  assign commit = step && pend_q;

  // Lowest free slot.
  always_comb begin
    free_onehot = '0;
    free_id     = '0;
    any_free    = 1'b0;
    for (int i = 0; i < int'(SLOTS); i++) begin
      if (!active_vec[i] && !any_free) begin
        free_onehot[i] = 1'b1;
        free_id        = IdW'(i + 1);
        any_free       = 1'b1;
      end
    end
  end

  assign cancel_ok = (id_q != '0) && (id_q <= IdW'(SLOTS));

  always_comb begin
    for (int i = 0; i < int'(SLOTS); i++) begin
      sel_vec[i] = (op_q == OP_SET) ? free_onehot[i] : (id_q == IdW'(i + 1));
    end
  end

  assign wr.set_en   = commit && (op_q == OP_SET) && any_free;
  assign wr.clr_en   = commit && (op_q == OP_CANCEL) && cancel_ok;
  assign wr.deadline = now_q + rel_q;
  assign wr.interval = per_q;

  assign tok[0] = tok0_q;

  for (genvar g = 0; g < SLOTS; g++) begin : g_cell
    ptt_cell #(
      .ID (g + 1)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .step_i    (step),
      .wr_i      (wr),
      .sel_i     (sel_vec[g]),
      .tok_i     (tok[g]),
      .tok_o     (tok[g+1]),
      .fire_o    (fire_vec[g]),
      .fire_id_o (fire_id[g]),
      .active_o  (active_vec[g])
    );
  end

  // At most one cell holds the token, so the fired id is a plain OR.
  always_comb begin
    fire_slot = '0;
    for (int i = 0; i < int'(SLOTS); i++) begin
      fire_slot = fire_slot | (fire_vec[i] ? fire_id[i] : '0);
    end
  end
  assign fire_any = |fire_vec;

  // Result selection; only one source is live in any cycle.
  always_comb begin
    load       = 1'b0;
    out_kind_d = KIND_SET_REPLY;
    out_slot_d = '0;
    out_next_d = '0;
    out_err_d  = 1'b0;
    out_last_d = 1'b1;
    if (commit) begin
      load = 1'b1;
      if (op_q == OP_SET) begin
        out_kind_d = KIND_SET_REPLY;
        out_slot_d = any_free ? free_id : '0;
      end else begin
        out_kind_d = KIND_CANCEL_ACK;
        out_slot_d = cancel_ok ? id_q : '0;
        out_err_d  = !cancel_ok;
      end
    end else if (step && fire_any) begin
      load       = 1'b1;
      out_kind_d = KIND_FIRED;
      out_slot_d = fire_slot;
      out_last_d = 1'b0;
    end else if (step && tok[SLOTS].valid) begin
      load       = 1'b1;
      out_kind_d = KIND_TICK_DONE;
      out_next_d = tok[SLOTS].min;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q       <= 1'b0;
      pend_q       <= 1'b0;
      tok0_q.valid <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (accept) begin
        busy_q <= (s_axis_tuser == OP_SET) || (s_axis_tuser == OP_CANCEL) ||
                  (s_axis_tuser == OP_TICK);
        pend_q <= (s_axis_tuser == OP_SET) || (s_axis_tuser == OP_CANCEL);
        tok0_q.valid <= (s_axis_tuser == OP_TICK);
        tok0_q.now   <= s_axis_tdata[31:0];
        tok0_q.min   <= NO_DEADLINE;
      end else begin
        if (step) begin
          tok0_q.valid <= 1'b0;
        end
        if (commit) begin
          pend_q <= 1'b0;
        end
        if (load && out_last_d) begin
          busy_q <= 1'b0;
        end
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q  <= s_axis_tuser;
      now_q <= s_axis_tdata[31:0];
      rel_q <= s_axis_tdata[63:32];
      per_q <= s_axis_tdata[95:64];
      id_q  <= s_axis_tdata[103:96];
    end
    if (load) begin
      out_kind_q <= out_kind_d;
      out_slot_q <= out_slot_d;
      out_next_q <= out_next_d;
      out_err_q  <= out_err_d;
      out_last_q <= out_last_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'b0, out_err_q, out_next_q, out_slot_q};
  assign m_axis_tuser  = out_kind_q;
  assign m_axis_tlast  = out_last_q;

  // Only one cell can see the token, so only one can fire in a cycle.
  `PTT_ASSERT(a_one_fire, $onehot0(fire_vec), "two cells fired in one cycle")
  // A pending set or cancel never overlaps a tick scan.
  `PTT_ASSERT_NEVER(a_pend_vs_scan, pend_q && (tok0_q.valid || (|fire_vec)),
                    "slot write overlaps a scan")
  // With no request in flight the token is gone from the row.
  `PTT_ASSERT_NEVER(a_idle_token, !busy_q && tok[SLOTS].valid,
                    "scan token alive while idle")
  // Loading the final result of a request frees the input side.
  `PTT_ASSERT(a_last_frees, (load && out_last_d && !accept) |=> !busy_q,
              "final result did not release the request")

endmodule

// File: rtl/ptt_cell.sv
// One timer slot: active flag, deadline and interval, plus one stage of the scan token.
// Depends on ptt_pkg.
module ptt_cell #(
  parameter int unsigned ID = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          step_i,
  input  ptt_pkg::wr_t  wr_i,
  input  logic          sel_i,
  input  ptt_pkg::tok_t tok_i,
  output ptt_pkg::tok_t tok_o,
  output logic          fire_o,
  output logic [7:0]    fire_id_o,
  output logic          active_o
);
  import ptt_pkg::*;

  logic             active_q, active_d;
  logic [TimeW-1:0] deadline_q, deadline_d;
  logic [TimeW-1:0] interval_q, interval_d;
  tok_t             tok_q, tok_d;

  logic             fire;
  logic             periodic;
  logic             act_n;
  logic [TimeW-1:0] dl_n;

  assign periodic = (interval_q != '0);
  assign fire     = step_i && tok_i.valid && active_q && (deadline_q <= tok_i.now);
  assign act_n    = fire ? periodic : active_q;
  assign dl_n     = (fire && periodic) ? (deadline_q + interval_q) : deadline_q;

  always_comb begin
    active_d   = active_q;
    deadline_d = deadline_q;
    interval_d = interval_q;
    if (sel_i && wr_i.set_en) begin
      active_d   = 1'b1;
      deadline_d = wr_i.deadline;
      interval_d = wr_i.interval;
    end else if (sel_i && wr_i.clr_en) begin
      active_d = 1'b0;
    end else if (fire) begin
      active_d   = act_n;
      deadline_d = dl_n;
    end
  end

  // The token picks up this slot's deadline as it leaves, if it is the new minimum.
  always_comb begin
    tok_d = tok_i;
    if (tok_i.valid && act_n && (dl_n < tok_i.min)) begin
      tok_d.min = dl_n;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      tok_q.valid <= 1'b0;
    end else begin
      active_q <= active_d;
      if (step_i) begin
        tok_q <= tok_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    deadline_q <= deadline_d;
    interval_q <= interval_d;
  end

  assign tok_o     = tok_q;
  assign fire_o    = fire;
  assign fire_id_o = 8'(ID);
  assign active_o  = active_q;

endmodule

// File: tb/periodic_timer_table_core_test.sv
// Self-checking testbench for periodic_timer_table_core: a queue-fed stream driver, a
// result monitor and a request-level predictor of the timer slots.
// Depends on ptt_pkg and the periodic_timer_table_core RTL.
`timescale 1ns / 100ps

module periodic_timer_table_core_test;
  import ptt_pkg::*;

  localparam int unsigned SLOT_COUNT = 4;
  // The fourth operation code is unused; the block must swallow such a request silently.
  localparam logic [1:0] OP_UNUSED = 2'd3;
  // Requests still queued below which neither side idles any more.
  localparam int unsigned CALM_TAIL = 40;
  localparam int unsigned RANDOM_REQS = 300;
  // Idle wait after the last expected result, longer than a whole tick scan.
  localparam int unsigned TAIL_CYCLES = 40;
  // Guard limit, well above the slowest correct run of about 330 requests with stalls.
  localparam int unsigned CYCLE_LIMIT = 200000;

  typedef struct {
    logic [1:0]  op;
    logic [31:0] now;
    logic [31:0] rel;
    logic [31:0] per;
    logic [7:0]  id;
    bit          drain_first;  // hold this request until every expected result is in
  } timer_req_t;

  typedef struct {
    logic [1:0]  kind;
    logic [7:0]  slot;
    logic [31:0] next_deadline;
    logic        error;
    logic        last;
  } timer_result_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic         req_valid = 1'b0;
  logic         req_ready;
  logic [103:0] req_data  = '0;  // now[31:0], delay[63:32], period[95:64],
                                 // slot_id[103:96]
  logic [1:0]   req_user  = '0;  // op[1:0]
  logic         res_valid;
  logic         res_ready = 1'b0;
  logic [47:0]  res_data;        // slot[7:0], next_deadline[39:8], error[40], zero[47:41]
  logic [1:0]   res_user;        // kind[1:0]
  logic         res_last;

  timer_req_t    pending_reqs[$];
  timer_result_t expected_results[$];
  timer_req_t    req_on_bus;
  int unsigned   send_gap  = 0;
  int unsigned   recv_stall = 0;
  int unsigned   mismatches = 0;
  int unsigned   cycles     = 0;

  // Shadow copy of the slot table.
  bit          shadow_active[SLOT_COUNT];
  logic [31:0] shadow_deadline[SLOT_COUNT];
  logic [31:0] shadow_interval[SLOT_COUNT];

  periodic_timer_table_core #(
    .SLOTS(SLOT_COUNT)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(req_valid),
    .s_axis_tready(req_ready),
    .s_axis_tdata (req_data),
    .s_axis_tuser (req_user),
    .m_axis_tvalid(res_valid),
    .m_axis_tready(res_ready),
    .m_axis_tdata (res_data),
    .m_axis_tuser (res_user),
    .m_axis_tlast (res_last)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Idling is allowed in most of the run, but not in one band out of three and never
  // in the calm tail, so both busy and back-to-back stretches occur.
  function automatic bit idling_allowed();
    return pending_reqs.size() > CALM_TAIL && (pending_reqs.size() / 40) % 3 != 1;
  endfunction

  function automatic void push_result(logic [1:0] kind, logic [7:0] slot,
                                      logic [31:0] next_deadline, logic error, logic last);
    timer_result_t r;
    r.kind          = kind;
    r.slot          = slot;
    r.next_deadline = next_deadline;
    r.error         = error;
    r.last          = last;
    expected_results.push_back(r);
  endfunction

  // Applies one accepted request to the shadow table and queues the results it causes.
  function automatic void predict_timer_results(timer_req_t r);
    logic [31:0] earliest;
    bit          placed;
    placed   = 1'b0;
    earliest = NO_DEADLINE;
    case (r.op)
      OP_SET: begin
        // Lowest free slot wins; a full table answers with slot 0.
        for (int i = 0; i < SLOT_COUNT; i++) begin
          if (!placed && !shadow_active[i]) begin
            placed             = 1'b1;
            shadow_active[i]   = 1'b1;
            shadow_interval[i] = r.per;
            shadow_deadline[i] = r.now + r.rel;
            push_result(KIND_SET_REPLY, 8'(i + 1), '0, 1'b0, 1'b1);
          end
        end
        if (!placed) push_result(KIND_SET_REPLY, 8'd0, '0, 1'b0, 1'b1);
      end
      OP_CANCEL: begin
        if (r.id >= 8'd1 && r.id <= 8'(SLOT_COUNT)) begin
          shadow_active[r.id - 1] = 1'b0;
          push_result(KIND_CANCEL_ACK, r.id, '0, 1'b0, 1'b1);
        end else begin
          push_result(KIND_CANCEL_ACK, 8'd0, '0, 1'b1, 1'b1);
        end
      end
      OP_TICK: begin
        // A late periodic timer fires only once per tick even if its moved deadline
        // is still due; the reload wraps modulo 2^32.
        for (int i = 0; i < SLOT_COUNT; i++) begin
          if (shadow_active[i] && shadow_deadline[i] <= r.now) begin
            push_result(KIND_FIRED, 8'(i + 1), '0, 1'b0, 1'b0);
            if (shadow_interval[i] != '0) shadow_deadline[i] += shadow_interval[i];
            else shadow_active[i] = 1'b0;
          end
          if (shadow_active[i] && shadow_deadline[i] < earliest)
            earliest = shadow_deadline[i];
        end
        push_result(KIND_TICK_DONE, 8'd0, earliest, 1'b0, 1'b1);
      end
      default: ;  // unused code: no results, no state change
    endcase
  endfunction

  // Request driver. A request stays on the bus until it is taken; a new one is only
  // loaded in a cycle where nothing is held, so each signal gets one assignment.
  always @(posedge clk_i or negedge rst_ni) begin
    bit holding;
    if (!rst_ni) begin
      req_valid <= 1'b0;
      req_data  <= '0;
      req_user  <= '0;
      send_gap  <= 0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
        shadow_active[i]   = 1'b0;
        shadow_deadline[i] = '0;
        shadow_interval[i] = '0;
      end
    end else begin
      holding = req_valid && !req_ready;
      if (req_valid && req_ready) predict_timer_results(req_on_bus);
      if (!holding) begin
        if (send_gap != 0) begin
          send_gap  <= send_gap - 1;
          req_valid <= 1'b0;
        end else if (pending_reqs.size() != 0 &&
                     !(pending_reqs[0].drain_first && expected_results.size() != 0)) begin
          if (idling_allowed() && $urandom_range(0, 7) == 0) begin
            send_gap  <= $urandom_range(0, 15);
            req_valid <= 1'b0;
          end else begin
            req_on_bus = pending_reqs.pop_front();
            req_valid <= 1'b1;
            req_data  <= {req_on_bus.id, req_on_bus.per, req_on_bus.rel, req_on_bus.now};
            req_user  <= req_on_bus.op;
          end
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(string what, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
      mismatches++;
    end
  endtask

  // Result monitor with random back-pressure. Outputs are sampled at the edge before
  // the block's own updates land, so the comparison sees the values that were taken.
  always @(posedge clk_i or negedge rst_ni) begin
    timer_result_t want;
    if (!rst_ni) begin
      res_ready  <= 1'b0;
      recv_stall <= 0;
    end else begin
      if (res_valid && res_ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t ns: unexpected result, expected none, actual kind %0h data %0h",
                   $time, res_user, res_data);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          check_field("kind", 32'(want.kind), 32'(res_user));
          check_field("slot", 32'(want.slot), 32'(res_data[7:0]));
          check_field("next_deadline", want.next_deadline, res_data[39:8]);
          check_field("error", 32'(want.error), 32'(res_data[40]));
          check_field("zero padding", 32'd0, 32'(res_data[47:41]));
          check_field("last", 32'(want.last), 32'(res_last));
        end
      end
      if (recv_stall != 0) begin
        recv_stall <= recv_stall - 1;
        res_ready  <= 1'b0;
      end else if (idling_allowed() && $urandom_range(0, 9) == 0) begin
        recv_stall <= $urandom_range(0, 15);
        res_ready  <= 1'b0;
      end else begin
        res_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic add_req(logic [1:0] op, logic [31:0] now, logic [31:0] rel,
                         logic [31:0] per, logic [7:0] id, bit drain_first = 1'b0);
    timer_req_t r;
    r.op          = op;
    r.now         = now;
    r.rel         = rel;
    r.per         = per;
    r.id          = id;
    r.drain_first = drain_first;
    pending_reqs.push_back(r);
  endtask

  initial begin
    logic [31:0] clock_ms;
    int unsigned counted;
    int unsigned pick;
    logic [1:0]  op;
    logic [31:0] rel;
    logic [31:0] per;
    logic [7:0]  id;

    // Directed part: empty table, cancel ids out of range and of a free slot, every
    // slot filled including a wrapping deadline, a full table, the unused code, an
    // expiring one-shot, a late periodic timer and a tick where all four slots fire.
    add_req(OP_TICK,   32'd5, '0, '0, '0);
    add_req(OP_CANCEL, '0, '0, '0, 8'd0);
    add_req(OP_CANCEL, '0, '0, '0, 8'd255);
    add_req(OP_CANCEL, '0, '0, '0, 8'(SLOT_COUNT + 1));
    add_req(OP_CANCEL, '0, '0, '0, 8'd1);
    add_req(OP_SET,    32'd0, 32'd10, 32'd0, '0);
    add_req(OP_SET,    32'd0, 32'd20, 32'd5, '0);
    add_req(OP_SET,    '1, '1, '1, '1);
    add_req(OP_SET,    32'd100, 32'd1000, 32'd0, '0);
    add_req(OP_SET,    32'd7, 32'd7, 32'd7, '0);
    add_req(OP_UNUSED, '1, '1, '1, '1);
    add_req(OP_TICK,   32'd15, '0, '0, '0);
    add_req(OP_TICK,   32'd50, '0, '0, '0);
    add_req(OP_SET,    32'd50, 32'd0, 32'd0, '0);
    add_req(OP_TICK,   '1, '0, '0, '0);
    add_req(OP_CANCEL, '0, '0, '0, 8'd2);
    add_req(OP_CANCEL, '0, '0, '0, 8'd3);
    add_req(OP_TICK,   '0, '0, '0, '0);
    add_req(OP_SET,    32'hFFFF_FFF0, 32'h20, 32'h8000_0000, '0);
    add_req(OP_TICK,   32'h10, '0, '0, '0);
    add_req(OP_TICK,   32'hFFFF_FFFF, '0, '0, '0);

    // Random part: mostly a plausible timeline of sets, cancels and ticks on an
    // advancing clock, with some noise requests and jumps of the clock.
    clock_ms = $urandom_range(0, 1000);
    counted  = 0;
    while (counted < RANDOM_REQS) begin
      pick = $urandom_range(0, 99);
      rel  = $urandom_range(0, 120);
      per  = ($urandom_range(0, 1) == 0) ? 32'd0 : 32'($urandom_range(1, 60));
      id   = 8'($urandom_range(1, SLOT_COUNT));
      if (pick < 8) begin
        op = 2'($urandom_range(0, 3));
        rel = $urandom;
        per = $urandom;
        id  = 8'($urandom_range(0, 255));
        add_req(op, $urandom, rel, per, id, counted % 75 == 0);
      end else if (pick < 12) begin
        clock_ms = $urandom;
        add_req(OP_TICK, clock_ms, $urandom, $urandom, '0, counted % 75 == 0);
        op = OP_TICK;
      end else begin
        clock_ms += $urandom_range(0, 60);
        if (pick < 45) begin
          op = OP_SET;
          if ($urandom_range(0, 9) == 0) rel = $urandom;
          if ($urandom_range(0, 9) == 0) per = $urandom;
        end else if (pick < 60) begin
          op = OP_CANCEL;
          if ($urandom_range(0, 5) == 0) id = 8'($urandom_range(0, 255));
        end else begin
          op = OP_TICK;
        end
        add_req(op, clock_ms, rel, per, id, counted % 75 == 0);
      end
      if (op != OP_UNUSED) counted++;
    end

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_reqs.size() != 0 || req_valid || expected_results.size() != 0)
      @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
